// ----- rtl/crm_pkg.sv -----
// Shared types and constants for the cartridge ROM address map.
// Used by every module of the block; depends on nothing.
package crm_pkg;

   localparam int RomBytesDefault = 4194304;
   localparam int SizeWidth       = 23;
   localparam int OffsetWidth     = 22;
   localparam int CpuAddrWidth    = 24;
   localparam int DataWidth       = 32;
   localparam int SumWidth        = 16;
   localparam int CsrAddrWidth    = 4;
   localparam int CsrDataWidth    = 32;
   localparam int QueueDepth      = 2;
   localparam int BankBits        = 7;
   localparam int PageWidth       = 8;

   localparam logic [1:0] MapLorom = 2'd0;
   localparam logic [1:0] MapHirom = 2'd1;

   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_BYTE,
      KIND_HALF,
      KIND_WORD
   } kind_type;

   typedef enum logic [1:0] {
      REG_MAP_MODE,
      REG_ROM_SIZE,
      REG_CHECKSUM,
      REG_COMPLEMENT
   } reg_index_type;

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_DIV,
      FE_PUSH
   } fe_state_type;

   typedef enum logic {
      BK_IDLE,
      BK_RUN
   } bk_state_type;

   typedef struct packed {
      kind_type                  kind;
      logic [CpuAddrWidth-1:0]   cpu_addr;
      logic [OffsetWidth-1:0]    load_offset;
      logic [7:0]                load_byte;
   } req_type;

   typedef struct packed {
      logic [DataWidth-1:0]      read_data;
      logic                      checksum_ok;
   } rsp_type;

   typedef struct packed {
      logic [1:0]                map_mode;
      logic [SizeWidth-1:0]      rom_size_bytes;
      logic [SumWidth-1:0]       stored_checksum;
      logic [SumWidth-1:0]       stored_complement;
   } cfg_type;

   // Translated request: per half a hit flag and a ROM offset
   typedef struct packed {
      kind_type                        kind;
      logic [1:0]                      hit;
      logic [1:0][OffsetWidth-1:0]     offset;
      logic                            load_ok;
      logic [OffsetWidth-1:0]          load_offset;
      logic [7:0]                      load_byte;
   } op_type;

endpackage

// ----- rtl/crm_front.sv -----
// Front end: accepts requests and translates CPU addresses to ROM offsets.
// Holds a bit-serial bank modulo unit. Depends on crm_pkg.
module crm_front #(
   parameter int RomBytes = crm_pkg::RomBytesDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  crm_pkg::cfg_type cfg,
   input  logic             req_valid,
   input  crm_pkg::req_type req_data,
   output logic             req_stall,
   output logic             q_push,
   output crm_pkg::op_type  q_data,
   input  logic             q_full
);

   localparam logic [crm_pkg::SizeWidth-1:0] RomBytesW = crm_pkg::SizeWidth'(RomBytes);
   localparam logic [2:0] DivSteps = 3'(crm_pkg::BankBits);
   localparam logic [2:0] TopBit   = 3'(crm_pkg::BankBits - 1);

   crm_pkg::fe_state_type                  state_ff, state_in;
   crm_pkg::req_type                       item_ff, item_in;
   crm_pkg::op_type                        op_ff, op_in;
   logic [crm_pkg::CpuAddrWidth-1:0]       addr_ff, addr_in;
   logic                                   half_ff, half_in;
   logic [crm_pkg::PageWidth-1:0]          rem_ff, rem_in;
   logic [2:0]                             cnt_ff, cnt_in;

   logic [crm_pkg::SizeWidth-1:0]          eff_size;
   logic [crm_pkg::PageWidth-1:0]          pages;
   logic [crm_pkg::BankBits-1:0]           bank7;
   logic [crm_pkg::PageWidth-1:0]          rem_shift;
   logic [crm_pkg::PageWidth-1:0]          rem_sub;
   logic [15:0]                            lo;
   logic [crm_pkg::OffsetWidth-1:0]        off;
   logic [crm_pkg::SizeWidth-1:0]          off_ext;
   logic [crm_pkg::SizeWidth-1:0]          off_next;
   logic                                   map_ok;
   logic                                   hit;
   logic [crm_pkg::CpuAddrWidth-1:0]       start_addr;
   logic [crm_pkg::BankBits-1:0]           start_bank;
   logic                                   start_skip;

   assign eff_size = (cfg.rom_size_bytes > RomBytesW) ? RomBytesW : cfg.rom_size_bytes;
   assign pages    = eff_size[crm_pkg::SizeWidth-1:15];
   assign bank7    = addr_ff[22:16];

   // one quotient bit per cycle of bank % pages
   assign rem_shift = {rem_ff[crm_pkg::PageWidth-2:0], bank7[TopBit - cnt_ff]};
   assign rem_sub   = (rem_shift >= pages) ? rem_shift - pages : rem_shift;

   assign lo       = addr_ff[15:0];
   assign off      = (cfg.map_mode == crm_pkg::MapLorom) ?
                     {rem_ff[crm_pkg::BankBits-1:0], lo[14:0]} : {bank7[5:0], lo};
   assign off_ext  = {1'b0, off};
   assign off_next = off_ext + 23'd1;
   assign map_ok   = (eff_size != '0) && lo[15] && (off_ext < eff_size) &&
                     ((cfg.map_mode == crm_pkg::MapLorom && pages != '0) ||
                      cfg.map_mode == crm_pkg::MapHirom);
   assign hit      = map_ok && (item_ff.kind == crm_pkg::KIND_BYTE || off_next < eff_size);

   // second half of a word starts at address + 2, wrapping in 24 bits
   assign start_addr = (state_ff == crm_pkg::FE_IDLE) ? req_data.cpu_addr : addr_ff + 24'd2;
   assign start_bank = start_addr[22:16];
   assign start_skip = (cfg.map_mode != crm_pkg::MapLorom) || ({1'b0, start_bank} < pages);

   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      op_in     = op_ff;
      addr_in   = addr_ff;
      half_in   = half_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      req_stall = (state_ff != crm_pkg::FE_IDLE);
      q_push    = 1'b0;
      q_data    = op_ff;
      unique case (state_ff)
         crm_pkg::FE_IDLE: begin
            if (req_valid) begin
               item_in           = req_data;
               op_in.kind        = req_data.kind;
               op_in.hit         = '0;
               op_in.offset      = '0;
               op_in.load_offset = req_data.load_offset;
               op_in.load_byte   = req_data.load_byte;
               op_in.load_ok     = ({1'b0, req_data.load_offset} < RomBytesW);
               if (req_data.kind == crm_pkg::KIND_LOAD) begin
                  state_in = crm_pkg::FE_PUSH;
               end else begin
                  addr_in  = start_addr;
                  half_in  = 1'b0;
                  rem_in   = start_skip ? {1'b0, start_bank} : '0;
                  cnt_in   = start_skip ? DivSteps : 3'd0;
                  state_in = crm_pkg::FE_DIV;
               end
            end
         end
         crm_pkg::FE_DIV: begin
            if (cnt_ff != DivSteps) begin
               rem_in = rem_sub;
               cnt_in = cnt_ff + 3'd1;
            end else begin
               op_in.hit[half_ff]    = hit;
               op_in.offset[half_ff] = off;
               if (item_ff.kind == crm_pkg::KIND_WORD && !half_ff) begin
                  half_in = 1'b1;
                  addr_in = start_addr;
                  rem_in  = start_skip ? {1'b0, start_bank} : '0;
                  cnt_in  = start_skip ? DivSteps : 3'd0;
               end else begin
                  state_in = crm_pkg::FE_PUSH;
               end
            end
         end
         crm_pkg::FE_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = crm_pkg::FE_IDLE;
            end
         end
         default: state_in = crm_pkg::FE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= crm_pkg::FE_IDLE;
      end else begin
         state_ff <= state_in;
      end
      item_ff <= item_in;
      op_ff   <= op_in;
      addr_ff <= addr_in;
      half_ff <= half_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

   a_push_then_ready: assert property (@(posedge clock) disable iff (reset)
      q_push |=> !req_stall)
      else $error("front not ready after handing off a request");

endmodule

// ----- rtl/crm_fifo.sv -----
// Short queue of translated requests between front and back end.
// Depends on crm_pkg for the entry type.
module crm_fifo #(
   parameter int Depth = crm_pkg::QueueDepth
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  crm_pkg::op_type push_data,
   output logic            full,
   input  logic            pop,
   output crm_pkg::op_type pop_data,
   output logic            empty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr  = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

   crm_pkg::op_type   entries_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;

   assign full     = (count_ff == DepthCnt);
   assign empty    = (count_ff == '0);
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue pop while empty");

endmodule

// ----- rtl/crm_back.sv -----
// Back end: ROM byte store, byte sum and result register.
// Runs one byte access per cycle on the store while a read is in progress. Depends on crm_pkg.
module crm_back #(
   parameter int RomBytes = crm_pkg::RomBytesDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  crm_pkg::cfg_type cfg,
   input  crm_pkg::op_type  q_data,
   input  logic             q_empty,
   output logic             q_pop,
   output logic             rsp_valid,
   output crm_pkg::rsp_type rsp_data,
   input  logic             rsp_stall
);

   localparam int AW = $clog2(RomBytes);

   logic [7:0]                       rom_mem [RomBytes];
   logic [7:0]                       rd_data_ff;

   crm_pkg::bk_state_type            state_ff, state_in;
   crm_pkg::op_type                  op_ff, op_in;
   logic [2:0]                       issue_ff, issue_in;
   logic                             pend_ff, pend_in;
   logic [1:0]                       pidx_ff, pidx_in;
   logic                             pmiss_ff, pmiss_in;
   logic [crm_pkg::DataWidth-1:0]    data_ff, data_in;
   logic [crm_pkg::SumWidth-1:0]     sum_ff, sum_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   crm_pkg::rsp_type                 rsp_ff, rsp_in;

   logic                             mem_we;
   logic [AW-1:0]                    mem_waddr;
   logic [7:0]                       mem_wdata;
   logic [AW-1:0]                    mem_raddr;

   logic                             out_free;
   logic [2:0]                       nbytes;
   logic                             ihalf;
   logic [crm_pkg::OffsetWidth-1:0]  ioff;
   logic [7:0]                       cap_byte;
   logic [crm_pkg::DataWidth-1:0]    data_cap;
   logic                             sum_ok;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign mem_waddr = q_data.load_offset[AW-1:0];
   assign mem_wdata = q_data.load_byte;

   assign ihalf    = issue_ff[1];
   assign ioff     = op_ff.offset[ihalf] + crm_pkg::OffsetWidth'(issue_ff[0]);
   assign cap_byte = pmiss_ff ? 8'hFF : rd_data_ff;
   assign sum_ok   = (sum_in == cfg.stored_checksum) &&
                     ((cfg.stored_checksum | cfg.stored_complement) != '0);

   always_comb begin
      data_cap = data_ff;
      data_cap[{pidx_ff, 3'b000} +: 8] = cap_byte;
   end

   always_comb begin
      unique case (op_ff.kind)
         crm_pkg::KIND_BYTE: nbytes = 3'd1;
         crm_pkg::KIND_HALF: nbytes = 3'd2;
         crm_pkg::KIND_WORD: nbytes = 3'd4;
         default:            nbytes = 3'd0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      pidx_in      = pidx_ff;
      pmiss_in     = pmiss_ff;
      data_in      = data_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_raddr    = ioff[AW-1:0];
      unique case (state_ff)
         crm_pkg::BK_IDLE: begin
            if (!q_empty && out_free) begin
               q_pop = 1'b1;
               if (q_data.kind == crm_pkg::KIND_LOAD) begin
                  if (q_data.load_ok) begin
                     mem_we = 1'b1;
                     sum_in = sum_ff + crm_pkg::SumWidth'(q_data.load_byte);
                  end
                  rsp_valid_in       = 1'b1;
                  rsp_in.read_data   = '0;
                  rsp_in.checksum_ok = sum_ok;
               end else begin
                  op_in    = q_data;
                  issue_in = 3'd0;
                  data_in  = '0;
                  state_in = crm_pkg::BK_RUN;
               end
            end
         end
         crm_pkg::BK_RUN: begin
            // issue the next byte while capturing the one read last cycle
            if (issue_ff != nbytes) begin
               pend_in  = 1'b1;
               pidx_in  = issue_ff[1:0];
               pmiss_in = !op_ff.hit[ihalf];
               issue_in = issue_ff + 3'd1;
            end
            if (pend_ff) begin
               data_in = data_cap;
               if (issue_ff == nbytes) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.read_data   = data_cap;
                  rsp_in.checksum_ok = sum_ok;
                  state_in           = crm_pkg::BK_IDLE;
               end
            end
         end
         default: state_in = crm_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         rom_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= rom_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= crm_pkg::BK_IDLE;
         pend_ff      <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff    <= op_in;
      issue_ff <= issue_in;
      pidx_ff  <= pidx_in;
      pmiss_ff <= pmiss_in;
      data_ff  <= data_in;
      rsp_ff   <= rsp_in;
   end

   a_run_no_pending_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == crm_pkg::BK_RUN) |-> !rsp_valid_ff)
      else $error("read started while a result was still held");

   a_sum_only_on_load: assert property (@(posedge clock) disable iff (reset)
      (sum_ff != $past(sum_ff)) |-> $past(mem_we))
      else $error("byte sum changed without a store write");

endmodule

// ----- rtl/cartridge_rom_address_map.sv -----
// Cartridge ROM address map: LoROM/HiROM translation over a byte store.
// Each LoROM half whose bank needs folding runs the bit-serial bank modulo first;
// HiROM halves and LoROM banks below the page count skip it. The front end takes
// no new request until the current one is pushed into the queue, and word reads
// make four byte accesses to the store, one per byte.
// Synchronous active-high reset clears control, byte sum and configuration registers; store is not cleared.
module cartridge_rom_address_map #(
   parameter int ROM_BYTES = crm_pkg::RomBytesDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  crm_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output crm_pkg::rsp_type                  rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [crm_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [crm_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [crm_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                              csr_pready
);

   crm_pkg::cfg_type        cfg_ff, cfg_in;
   crm_pkg::reg_index_type  reg_index;
   logic                    csr_write;

   logic                    q_push;
   crm_pkg::op_type         q_push_data;
   logic                    q_full;
   logic                    q_pop;
   crm_pkg::op_type         q_pop_data;
   logic                    q_empty;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = crm_pkg::reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_index)
            crm_pkg::REG_MAP_MODE:   cfg_in.map_mode          = csr_pwdata[1:0];
            crm_pkg::REG_ROM_SIZE:   cfg_in.rom_size_bytes    =
                                        csr_pwdata[crm_pkg::SizeWidth-1:0];
            crm_pkg::REG_CHECKSUM:   cfg_in.stored_checksum   =
                                        csr_pwdata[crm_pkg::SumWidth-1:0];
            crm_pkg::REG_COMPLEMENT: cfg_in.stored_complement =
                                        csr_pwdata[crm_pkg::SumWidth-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         crm_pkg::REG_MAP_MODE:   csr_prdata = crm_pkg::CsrDataWidth'(cfg_ff.map_mode);
         crm_pkg::REG_ROM_SIZE:   csr_prdata = crm_pkg::CsrDataWidth'(cfg_ff.rom_size_bytes);
         crm_pkg::REG_CHECKSUM:   csr_prdata = crm_pkg::CsrDataWidth'(cfg_ff.stored_checksum);
         crm_pkg::REG_COMPLEMENT: csr_prdata =
                                     crm_pkg::CsrDataWidth'(cfg_ff.stored_complement);
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   crm_front #(
      .RomBytes (ROM_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .q_push    (q_push),
      .q_data    (q_push_data),
      .q_full    (q_full)
   );

   crm_fifo #(
      .Depth (crm_pkg::QueueDepth)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   crm_back #(
      .RomBytes (ROM_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_data    (q_pop_data),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule
